FILE: hdl/i2cm_pkg.sv
// Shared types and constants for the I2C byte transfer master.
package i2cm_pkg;

  localparam int PhaseW = 5;

  localparam logic [15:0] STRETCH_LIMIT_RESET = 16'd1000;
  localparam logic        REG_STRETCH_LIMIT   = 1'b0;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_ADDR_NACK = 2'd1;
  localparam logic [1:0] STAT_DATA_NACK = 2'd2;
  localparam logic [1:0] STAT_TIMEOUT   = 2'd3;

  typedef struct packed {
    logic       begin_req;
    logic       is_read;
    logic [6:0] slave_address;
    logic [7:0] byte_count;
    logic [7:0] tx_byte;
    logic       sda_in;
    logic       scl_in;
  } in_t;

  typedef struct packed {
    logic       scl_low;
    logic       sda_low;
    logic       tx_take;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } out_t;

endpackage

FILE: hdl/i2cm_regs.sv
// APB configuration register bank holding the clock stretch limit.
module i2cm_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [15:0] stretch_limit
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      stretch_limit <= i2cm_pkg::STRETCH_LIMIT_RESET;
    end else if (wr_en && paddr[2] == i2cm_pkg::REG_STRETCH_LIMIT) begin
      stretch_limit <= pwdata[15:0];
    end
  end

  always_comb begin
    if (paddr[2] == i2cm_pkg::REG_STRETCH_LIMIT) begin
      prdata = {16'd0, stretch_limit};
    end else begin
      prdata = 32'd0;
    end
  end

endmodule

FILE: hdl/i2cm_core.sv
// Bus sequencer: transfer state registers and the per-tick next-state and drive logic.
module i2cm_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  i2cm_pkg::in_t    word,
  input  logic [15:0]      stretch_limit,
  output i2cm_pkg::out_t   result
);

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_START_B  = 5'd2;
  localparam logic [4:0] PH_W_LOAD   = 5'd3;
  localparam logic [4:0] PH_W_SET    = 5'd4;
  localparam logic [4:0] PH_W_HIGH   = 5'd5;
  localparam logic [4:0] PH_W_LOW    = 5'd6;
  localparam logic [4:0] PH_WA_SETUP = 5'd7;
  localparam logic [4:0] PH_WA_HIGH  = 5'd8;
  localparam logic [4:0] PH_WA_LOW   = 5'd9;
  localparam logic [4:0] PH_R_WAIT   = 5'd10;
  localparam logic [4:0] PH_R_HOLD   = 5'd11;
  localparam logic [4:0] PH_R_LOW    = 5'd12;
  localparam logic [4:0] PH_RA_SETUP = 5'd13;
  localparam logic [4:0] PH_RA_HIGH  = 5'd14;
  localparam logic [4:0] PH_RA_LOW   = 5'd15;
  localparam logic [4:0] PH_STOP_A   = 5'd16;
  localparam logic [4:0] PH_STOP_B   = 5'd17;
  localparam logic [4:0] PH_STOP_C   = 5'd18;

  logic [i2cm_pkg::PhaseW-1:0] phase, phase_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [7:0]  bytes_left, bytes_left_next;
  logic [15:0] stretch_count, stretch_count_next;
  logic [7:0]  addr_dir, addr_dir_next;
  logic [1:0]  result_code, result_code_next;
  logic        addr_stage, addr_stage_next;

  logic [3:0]  bit_inc;
  logic [15:0] stretch_inc;
  logic [7:0]  bytes_dec;
  logic        more_bytes;

  assign bit_inc     = bit_index + 4'd1;
  assign stretch_inc = stretch_count + 16'd1;
  assign bytes_dec   = bytes_left - 8'd1;
  assign more_bytes  = bytes_left > 8'd1;

  always_comb begin
    phase_next         = phase;
    bit_index_next     = bit_index;
    shift_reg_next     = shift_reg;
    bytes_left_next    = bytes_left;
    stretch_count_next = stretch_count;
    addr_dir_next      = addr_dir;
    result_code_next   = result_code;
    addr_stage_next    = addr_stage;
    result             = '0;
    result.busy_res    = 1'b1;
    case (phase)
      PH_IDLE: begin
        result.busy_res = 1'b0;
        if (word.begin_req) begin
          addr_dir_next    = {word.slave_address, word.is_read};
          bytes_left_next  = word.byte_count;
          result_code_next = i2cm_pkg::STAT_OK;
          addr_stage_next  = 1'b1;
          result.busy_res  = 1'b1;
          result.sda_low   = 1'b1;
          phase_next       = PH_START_B;
        end
      end
      PH_START_B: begin
        result.scl_low = 1'b1;
        result.sda_low = 1'b1;
        shift_reg_next = addr_dir;
        bit_index_next = 4'd0;
        phase_next     = PH_W_SET;
      end
      PH_W_LOAD: begin
        shift_reg_next  = word.tx_byte;
        bytes_left_next = bytes_dec;
        bit_index_next  = 4'd0;
        result.scl_low  = 1'b1;
        result.sda_low  = ~word.tx_byte[7];
        phase_next      = PH_W_HIGH;
      end
      PH_W_SET: begin
        result.scl_low = 1'b1;
        result.sda_low = ~shift_reg[7];
        phase_next     = PH_W_HIGH;
      end
      PH_W_HIGH: begin
        result.sda_low = ~shift_reg[7];
        phase_next     = PH_W_LOW;
      end
      PH_W_LOW: begin
        result.scl_low = 1'b1;
        result.sda_low = ~shift_reg[7];
        shift_reg_next = {shift_reg[6:0], 1'b0};
        bit_index_next = bit_inc;
        phase_next     = bit_inc[3] ? PH_WA_SETUP : PH_W_SET;
      end
      PH_WA_SETUP: begin
        result.scl_low = 1'b1;
        phase_next     = PH_WA_HIGH;
      end
      PH_WA_HIGH: begin
        if (word.sda_in) begin
          result_code_next = addr_stage ? i2cm_pkg::STAT_ADDR_NACK
                                        : i2cm_pkg::STAT_DATA_NACK;
        end
        phase_next = PH_WA_LOW;
      end
      PH_WA_LOW: begin
        result.scl_low = 1'b1;
        if (result_code != i2cm_pkg::STAT_OK || bytes_left == 8'd0) begin
          phase_next = PH_STOP_A;
        end else if (addr_stage && addr_dir[0]) begin
          shift_reg_next     = 8'd0;
          bit_index_next     = 4'd0;
          stretch_count_next = 16'd0;
          phase_next         = PH_R_WAIT;
        end else begin
          result.tx_take = 1'b1;
          phase_next     = PH_W_LOAD;
        end
        addr_stage_next = 1'b0;
      end
      PH_R_WAIT: begin
        if (word.scl_in) begin
          shift_reg_next     = {shift_reg[6:0], word.sda_in};
          stretch_count_next = 16'd0;
          phase_next         = PH_R_HOLD;
        end else if (stretch_inc >= stretch_limit) begin
          result.rx_valid    = 1'b1;
          result_code_next   = i2cm_pkg::STAT_TIMEOUT;
          stretch_count_next = 16'd0;
          phase_next         = PH_STOP_A;
        end else begin
          stretch_count_next = stretch_inc;
        end
      end
      PH_R_HOLD: begin
        phase_next = PH_R_LOW;
      end
      PH_R_LOW: begin
        result.scl_low = 1'b1;
        bit_index_next = bit_inc;
        phase_next     = bit_inc[3] ? PH_RA_SETUP : PH_R_WAIT;
      end
      PH_RA_SETUP: begin
        result.scl_low  = 1'b1;
        result.sda_low  = more_bytes;
        result.rx_valid = 1'b1;
        result.rx_byte  = shift_reg;
        phase_next      = PH_RA_HIGH;
      end
      PH_RA_HIGH: begin
        result.sda_low = more_bytes;
        phase_next     = PH_RA_LOW;
      end
      PH_RA_LOW: begin
        result.scl_low  = 1'b1;
        result.sda_low  = more_bytes;
        bytes_left_next = bytes_dec;
        if (bytes_dec == 8'd0) begin
          phase_next = PH_STOP_A;
        end else begin
          shift_reg_next     = 8'd0;
          bit_index_next     = 4'd0;
          stretch_count_next = 16'd0;
          phase_next         = PH_R_WAIT;
        end
      end
      PH_STOP_A: begin
        result.scl_low = 1'b1;
        result.sda_low = 1'b1;
        phase_next     = PH_STOP_B;
      end
      PH_STOP_B: begin
        result.sda_low = 1'b1;
        phase_next     = PH_STOP_C;
      end
      PH_STOP_C: begin
        result.busy_res = 1'b0;
        result.done_res = 1'b1;
        result.status   = result_code;
        phase_next      = PH_IDLE;
      end
      default: begin
        result.busy_res = 1'b0;
        phase_next      = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      bit_index     <= 4'd0;
      shift_reg     <= 8'd0;
      bytes_left    <= 8'd0;
      stretch_count <= 16'd0;
      addr_dir      <= 8'd0;
      result_code   <= 2'd0;
      addr_stage    <= 1'b0;
    end else if (step) begin
      phase         <= phase_next;
      bit_index     <= bit_index_next;
      shift_reg     <= shift_reg_next;
      bytes_left    <= bytes_left_next;
      stretch_count <= stretch_count_next;
      addr_dir      <= addr_dir_next;
      result_code   <= result_code_next;
      addr_stage    <= addr_stage_next;
    end
  end

endmodule

FILE: hdl/i2c_master_byte_transfer.sv
// Top level of the I2C byte transfer master: handshake, result register and register bank.
// Each input word is one bus delay tick and yields exactly one result word. For each word
// the sequencer state advances and the result register loads on the edge that accepts
// the word, so a new word is taken every cycle while the result register is free or
// being drained in the same cycle. The register bank holds the clock stretch limit.
module i2c_master_byte_transfer (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  i2cm_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output i2cm_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  logic           accept;
  logic [15:0]    stretch_limit;
  i2cm_pkg::out_t result;

  assign in_ready = ~out_valid | out_ready;
  assign accept   = in_valid & in_ready;

  i2cm_regs u_regs (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .stretch_limit (stretch_limit)
  );

  i2cm_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (accept),
    .word          (in_data),
    .stretch_limit (stretch_limit),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

endmodule

FILE: hdl/i2cm_check.sv
// Port-level checker for the I2C byte transfer master and its bind.
module i2cm_check (
  input logic           clk,
  input logic           rst,
  input logic           out_valid,
  input logic           out_ready,
  input i2cm_pkg::out_t out_data,
  input logic           pready
);

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.done_res && out_data.busy_res))
    else $error("Done and busy are both set in one word.");

  a_status_on_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.done_res) |-> out_data.status == i2cm_pkg::STAT_OK)
    else $error("Nonzero status outside the done word.");

  a_rx_byte_gated: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.rx_valid) |-> out_data.rx_byte == 8'd0)
    else $error("Received byte is nonzero without rx_valid.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("Stalled result word changed or dropped.");

  a_pready: assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("pready went low.");

endmodule

bind i2c_master_byte_transfer i2cm_check u_check (.*);

FILE: test/tb.sv
// Self-checking testbench for the I2C byte transfer master, with a tick-level predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int InW = $bits(i2cm_pkg::in_t);
  localparam int CycleLimit = 2_000_000;
  localparam logic [2:0] STRETCH_ADDR = {i2cm_pkg::REG_STRETCH_LIMIT, 2'b00};
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START_A, ST_START_B, ST_W_LOAD, ST_W_SET, ST_W_HIGH, ST_W_LOW,
    ST_WA_SETUP, ST_WA_HIGH, ST_WA_LOW, ST_R_WAIT, ST_R_HOLD, ST_R_LOW,
    ST_RA_SETUP, ST_RA_HIGH, ST_RA_LOW, ST_STOP_A, ST_STOP_B, ST_STOP_C
  } seq_t;

  typedef struct {
    seq_t        ph;
    logic [3:0]  bit_idx;
    logic [7:0]  shreg;
    logic [7:0]  left;
    logic [15:0] stretch_cnt;
    logic [15:0] stretch_lim;
    logic [7:0]  addr_byte;
    logic [1:0]  code;
    logic        on_addr;
  } master_t;

  logic           clk;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  i2cm_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  i2cm_pkg::out_t out_data;
  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [2:0]     paddr = '0;
  logic [31:0]    pwdata = '0;
  logic [31:0]    prdata;
  logic           pready;

  master_t        plan;
  master_t        track;
  i2cm_pkg::out_t pending_lines[$];
  int             words_sent = 0;
  int             words_seen = 0;
  int             errors = 0;
  int             transfers = 0;
  int             finished_with[4] = '{0, 0, 0, 0};
  int             hold_len = 0;
  bit             send_quiet = 1'b0;
  bit             recv_quiet = 1'b0;

  i2c_master_byte_transfer uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic master_t fresh_master();
    master_t s;
    s.ph = ST_IDLE;
    s.bit_idx = '0;
    s.shreg = '0;
    s.left = '0;
    s.stretch_cnt = '0;
    s.stretch_lim = i2cm_pkg::STRETCH_LIMIT_RESET;
    s.addr_byte = '0;
    s.code = i2cm_pkg::STAT_OK;
    s.on_addr = 1'b0;
    return s;
  endfunction

  function automatic void start_read_byte(inout master_t s);
    s.shreg = '0;
    s.bit_idx = '0;
    s.stretch_cnt = '0;
    s.ph = ST_R_WAIT;
  endfunction

  // Advances the sequencer by one bus tick and returns the line levels for it.
  function automatic i2cm_pkg::out_t master_tick(inout master_t s, input i2cm_pkg::in_t w);
    i2cm_pkg::out_t o;
    o = '0;
    o.busy_res = 1'b1;
    case (s.ph)
      ST_IDLE: begin
        o.busy_res = 1'b0;
        if (w.begin_req) begin
          s.addr_byte = {w.slave_address, w.is_read};
          s.left = w.byte_count;
          s.code = i2cm_pkg::STAT_OK;
          s.on_addr = 1'b1;
          o.busy_res = 1'b1;
          o.sda_low = 1'b1;
          s.ph = ST_START_B;
        end
      end
      ST_START_B: begin
        o.scl_low = 1'b1;
        o.sda_low = 1'b1;
        s.shreg = s.addr_byte;
        s.bit_idx = '0;
        s.ph = ST_W_SET;
      end
      ST_W_LOAD: begin
        s.shreg = w.tx_byte;
        s.left = s.left - 8'd1;
        s.bit_idx = '0;
        o.scl_low = 1'b1;
        o.sda_low = !s.shreg[7];
        s.ph = ST_W_HIGH;
      end
      ST_W_SET: begin
        o.scl_low = 1'b1;
        o.sda_low = !s.shreg[7];
        s.ph = ST_W_HIGH;
      end
      ST_W_HIGH: begin
        o.sda_low = !s.shreg[7];
        s.ph = ST_W_LOW;
      end
      ST_W_LOW: begin
        o.scl_low = 1'b1;
        o.sda_low = !s.shreg[7];
        s.shreg = {s.shreg[6:0], 1'b0};
        s.bit_idx = s.bit_idx + 4'd1;
        s.ph = (s.bit_idx >= 4'd8) ? ST_WA_SETUP : ST_W_SET;
      end
      ST_WA_SETUP: begin
        o.scl_low = 1'b1;
        s.ph = ST_WA_HIGH;
      end
      ST_WA_HIGH: begin
        if (w.sda_in) begin
          s.code = s.on_addr ? i2cm_pkg::STAT_ADDR_NACK : i2cm_pkg::STAT_DATA_NACK;
        end
        s.ph = ST_WA_LOW;
      end
      ST_WA_LOW: begin
        o.scl_low = 1'b1;
        if (s.code != i2cm_pkg::STAT_OK || s.left == 8'd0) begin
          s.ph = ST_STOP_A;
        end else if (s.on_addr && s.addr_byte[0]) begin
          start_read_byte(s);
        end else begin
          o.tx_take = 1'b1;
          s.ph = ST_W_LOAD;
        end
        s.on_addr = 1'b0;
      end
      ST_R_WAIT: begin
        if (w.scl_in) begin
          s.shreg = {s.shreg[6:0], w.sda_in};
          s.stretch_cnt = '0;
          s.ph = ST_R_HOLD;
        end else begin
          s.stretch_cnt = s.stretch_cnt + 16'd1;
          if (s.stretch_cnt >= s.stretch_lim) begin
            o.rx_valid = 1'b1;
            s.code = i2cm_pkg::STAT_TIMEOUT;
            s.stretch_cnt = '0;
            s.ph = ST_STOP_A;
          end
        end
      end
      ST_R_HOLD: s.ph = ST_R_LOW;
      ST_R_LOW: begin
        o.scl_low = 1'b1;
        s.bit_idx = s.bit_idx + 4'd1;
        s.ph = (s.bit_idx >= 4'd8) ? ST_RA_SETUP : ST_R_WAIT;
      end
      ST_RA_SETUP: begin
        o.scl_low = 1'b1;
        o.sda_low = (s.left > 8'd1);
        o.rx_valid = 1'b1;
        o.rx_byte = s.shreg;
        s.ph = ST_RA_HIGH;
      end
      ST_RA_HIGH: begin
        o.sda_low = (s.left > 8'd1);
        s.ph = ST_RA_LOW;
      end
      ST_RA_LOW: begin
        o.scl_low = 1'b1;
        o.sda_low = (s.left > 8'd1);
        s.left = s.left - 8'd1;
        if (s.left == 8'd0) s.ph = ST_STOP_A;
        else start_read_byte(s);
      end
      ST_STOP_A: begin
        o.scl_low = 1'b1;
        o.sda_low = 1'b1;
        s.ph = ST_STOP_B;
      end
      ST_STOP_B: begin
        o.sda_low = 1'b1;
        s.ph = ST_STOP_C;
      end
      ST_STOP_C: begin
        o.busy_res = 1'b0;
        o.done_res = 1'b1;
        o.status = s.code;
        s.ph = ST_IDLE;
      end
      default: begin
        o.busy_res = 1'b0;
        s.ph = ST_IDLE;
      end
    endcase
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    else if (r < 95) return $urandom_range(1, 3);
    else return $urandom_range(8, 25);
  endfunction

  function automatic i2cm_pkg::in_t random_word();
    return i2cm_pkg::in_t'(InW'($urandom));
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    i2cm_pkg::out_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_lines.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected result word, expected none, got %h", $time, out_data);
        end else begin
          want = pending_lines.pop_front();
          check_field("scl_low", want.scl_low, out_data.scl_low);
          check_field("sda_low", want.sda_low, out_data.sda_low);
          check_field("tx_take", want.tx_take, out_data.tx_take);
          check_field("rx_byte", want.rx_byte, out_data.rx_byte);
          check_field("rx_valid", want.rx_valid, out_data.rx_valid);
          check_field("busy_res", want.busy_res, out_data.busy_res);
          check_field("done_res", want.done_res, out_data.done_res);
          check_field("status", want.status, out_data.status);
          if (want.done_res) finished_with[want.status]++;
        end
        words_seen++;
      end
      if (in_valid && in_ready) pending_lines.push_back(master_tick(track, in_data));
      if (psel && penable && pwrite && pready && paddr == STRETCH_ADDR)
        track.stretch_lim = pwdata[15:0];
    end
  end

  // The receiver stalls at random, or for a requested stretch of cycles.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        stall = hold_len;
        hold_len = 0;
      end else if (stall == 0) begin
        stall = recv_quiet ? 0 : pick_gap();
      end
      out_ready <= (stall == 0);
      if (stall > 0) stall--;
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Timed out after %0d cycles with %0d words outstanding.",
             CycleLimit, words_sent - words_seen);
    $display("i2c_master_byte_transfer test failed");
    $finish;
  end

  task automatic send_word(i2cm_pkg::in_t w);
    int gap;
    gap = send_quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= w;
    in_valid <= 1'b1;
    void'(master_tick(plan, w));
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_seen < words_sent);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read_check(logic [2:0] addr, logic [15:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[15:0] !== want) begin
      errors++;
      $display("%0t ns: stretch_limit readback mismatch, expected %h, got %h",
               $time, want, prdata[15:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_limit(logic [15:0] lim);
    drain();
    apb_write(STRETCH_ADDR, {16'd0, lim});
    plan.stretch_lim = lim;
    apb_read_check(STRETCH_ADDR, lim);
  endtask

  task automatic idle_ticks(int n);
    i2cm_pkg::in_t w;
    repeat (n) begin
      w = random_word();
      w.begin_req = 1'b0;
      send_word(w);
    end
  endtask

  // Plays the slave: ACKs every slot except the chosen one, stretches read bits at the
  // given percentage, and fills everything else with noise.
  task automatic run_transfer(bit rd, logic [6:0] adr, logic [7:0] cnt, int nack_slot,
                              int stretch_pct, int tx_fixed);
    i2cm_pkg::in_t w;
    int            slot;
    slot = 0;
    w = random_word();
    w.begin_req = 1'b1;
    w.is_read = rd;
    w.slave_address = adr;
    w.byte_count = cnt;
    send_word(w);
    transfers++;
    while (plan.ph != ST_IDLE) begin
      w = random_word();
      if (tx_fixed >= 0) w.tx_byte = 8'(tx_fixed);
      if (plan.ph == ST_WA_HIGH) begin
        w.sda_in = (slot == nack_slot);
        slot++;
      end else if (plan.ph == ST_R_WAIT) begin
        w.scl_in = ($urandom_range(99) >= stretch_pct);
      end
      send_word(w);
    end
  endtask

  task automatic test_registers();
    apb_read_check(STRETCH_ADDR, i2cm_pkg::STRETCH_LIMIT_RESET);
    apb_write(SPARE_ADDR, 32'h0000_0005);
    apb_read_check(STRETCH_ADDR, i2cm_pkg::STRETCH_LIMIT_RESET);
  endtask

  task automatic test_write_transfers();
    run_transfer(1'b0, 7'h7F, 8'd0, -1, 0, -1);
    run_transfer(1'b0, 7'h00, 8'd1, -1, 0, 8'hFF);
    run_transfer(1'b0, 7'h2A, 8'd2, 0, 0, -1);
    run_transfer(1'b0, 7'h11, 8'd2, 1, 0, -1);
    idle_ticks(4);
  endtask

  task automatic test_read_transfers();
    run_transfer(1'b1, 7'h7F, 8'd1, -1, 0, -1);
    run_transfer(1'b1, 7'h00, 8'd1, -1, 30, -1);
    run_transfer(1'b1, 7'h5A, 8'd0, -1, 0, -1);
  endtask

  task automatic test_stretch_timeouts();
    set_limit(16'd1);
    run_transfer(1'b1, 7'h21, 8'd2, -1, 100, -1);
    set_limit(16'd0);
    run_transfer(1'b1, 7'h22, 8'd1, -1, 100, -1);
  endtask

  // Full byte counts, cut short by a data NACK on a write and a stretch timeout on a read.
  task automatic test_long_transfers();
    set_limit(16'd2);
    send_quiet = 1'b1;
    recv_quiet = 1'b1;
    run_transfer(1'b0, 7'h4C, 8'd255, 2, 0, -1);
    run_transfer(1'b1, 7'h4D, 8'd255, -1, 30, -1);
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  task automatic test_backpressure();
    set_limit(16'hFFFF);
    hold_len = 60;
    send_quiet = 1'b1;
    run_transfer(1'b1, 7'h42, 8'd2, -1, 10, -1);
    send_quiet = 1'b0;
    drain();
  endtask

  task automatic test_random_traffic(logic [15:0] lim, int nticks);
    int         start;
    logic [7:0] cnt;
    int         nack;
    int         pct;
    set_limit(lim);
    start = words_sent;
    while (words_sent - start < nticks) begin
      send_quiet = ($urandom_range(3) == 0);
      recv_quiet = ($urandom_range(3) == 0);
      if ($urandom_range(9) == 0) begin
        idle_ticks($urandom_range(1, 6));
      end else begin
        cnt = ($urandom_range(9) == 0) ? 8'($urandom_range(4, 16)) : 8'($urandom_range(3));
        nack = ($urandom_range(9) < 7) ? -1 : $urandom_range(0, cnt);
        pct = ($urandom_range(1) == 0) ? 0 : $urandom_range(5, 60);
        run_transfer(1'($urandom_range(1)), 7'($urandom_range(127)), cnt, nack, pct, -1);
      end
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
  endtask

  initial begin
    plan = fresh_master();
    track = fresh_master();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_registers();
    test_write_transfers();
    test_read_transfers();
    test_stretch_timeouts();
    test_long_transfers();
    test_backpressure();
    test_random_traffic(16'($urandom_range(1, 4)), 80);
    drain();
    repeat (8) @(posedge clk);
    if (pending_lines.size() != 0) begin
      errors++;
      $display("%0t ns: %0d expected result words never arrived, expected 0, got %0d",
               $time, pending_lines.size(), pending_lines.size());
    end
    $display("Ran %0d transfers over %0d bus ticks, checked every result word.",
             transfers, words_seen);
    $display("Endings seen: %0d clean, %0d address NACK, %0d data NACK, %0d stretch timeout.",
             finished_with[i2cm_pkg::STAT_OK], finished_with[i2cm_pkg::STAT_ADDR_NACK],
             finished_with[i2cm_pkg::STAT_DATA_NACK], finished_with[i2cm_pkg::STAT_TIMEOUT]);
    if (errors == 0) begin
      $display("i2c_master_byte_transfer test passed");
    end else begin
      $display("i2c_master_byte_transfer test failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/i2cm_pkg.sv
hdl/i2cm_regs.sv
hdl/i2cm_core.sv
hdl/i2c_master_byte_transfer.sv
hdl/i2cm_check.sv
test/tb.sv
